@@ hw/rtl/tdfa_pkg.sv @@
// Shared types, request codes and defaults for the DFA matcher.
package tdfa_pkg;

	// Default sizes of the automaton
	localparam int ALPHABET_DEF   = 128;
	localparam int MAX_STATES_DEF = 256;

	// Depth of the queue between the front and the execute part
	localparam int QUEUE_DEPTH = 2;

	// Request codes carried by req_type
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_MARK  = 2'd1;
	localparam logic [1:0] REQ_FEED  = 2'd2;

	// Dead marker as written in dest_state
	localparam logic [8:0] DEAD_DEST = 9'h1FF;

	// Classified operation handed to the execute part
	typedef enum logic [2:0] {
		OP_NOP,
		OP_WRITE,
		OP_MARK,
		OP_FEED,
		OP_KILL,
		OP_END
	} tdfa_opcode_t;

	typedef struct packed {
		tdfa_opcode_t op;
		logic [6:0]   sym;
		logic [7:0]   src;
		logic         dst_dead;
		logic [7:0]   dst;
	} tdfa_op_t;

endpackage

@@ hw/rtl/tdfa_ram.sv @@
// Generic simple dual-port RAM with registered read.
module tdfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds its data when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/tdfa_front.sv @@
// Front part: accepts input transactions and classifies them into operations.
module tdfa_front #(
	parameter int ALPHABET   = tdfa_pkg::ALPHABET_DEF,
	parameter int MAX_STATES = tdfa_pkg::MAX_STATES_DEF
) (
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       req_type,
	input  logic [7:0]       state_index,
	input  logic [6:0]       symbol,
	input  logic [8:0]       dest_state,
	input  logic             busy,
	input  logic             q_full,
	output logic             push,
	output tdfa_pkg::tdfa_op_t push_op
);

	import tdfa_pkg::*;

	logic src_ok;
	logic sym_ok;
	logic dst_dead;
	logic dst_ok;
	tdfa_opcode_t op;

	// Range checks on the request fields
	assign src_ok   = 32'(state_index) < MAX_STATES;
	assign sym_ok   = 32'(symbol) < ALPHABET;
	assign dst_dead = dest_state == DEAD_DEST;
	assign dst_ok   = dst_dead || (!dest_state[8] && (32'(dest_state[7:0]) < MAX_STATES));

	// Classify the request; ignored requests become no-ops
	always_comb begin
		op = OP_NOP;
		case (req_type)
			REQ_WRITE: begin
				if (src_ok && sym_ok && dst_ok) begin
					op = OP_WRITE;
				end
			end
			REQ_MARK: begin
				if (src_ok) begin
					op = OP_MARK;
				end
			end
			REQ_FEED: begin
				if (symbol == 7'd0) begin
					op = OP_END;
				end else if (sym_ok) begin
					op = OP_FEED;
				end else begin
					op = OP_KILL;
				end
			end
			default: begin
				op = OP_NOP;
			end
		endcase
	end

	// Accept while the queue has room and the store is not being cleared
	assign in_ready = !q_full && !busy;
	assign push     = in_valid && in_ready && (op != OP_NOP);

	assign push_op.op       = op;
	assign push_op.sym      = symbol;
	assign push_op.src      = state_index;
	assign push_op.dst_dead = dst_dead;
	assign push_op.dst      = dest_state[7:0];

endmodule

@@ hw/rtl/tdfa_queue.sv @@
// Short queue of classified operations between the front and execute parts.
module tdfa_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tdfa_pkg::tdfa_op_t push_op,
	output logic               full,
	output logic               pop_valid,
	output tdfa_pkg::tdfa_op_t pop_op,
	input  logic               pop
);

	import tdfa_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	tdfa_op_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = count_q == CW'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_op    = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/tdfa_exec.sv @@
// Execute part: transition and final-flag stores, run state and result register.
module tdfa_exec #(
	parameter int ALPHABET   = tdfa_pkg::ALPHABET_DEF,
	parameter int MAX_STATES = tdfa_pkg::MAX_STATES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  tdfa_pkg::tdfa_op_t q_op,
	output logic               q_pop,
	output logic               busy,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               accepted,
	output logic               went_dead
);

	import tdfa_pkg::*;

	// State indexes never exceed eight bits, symbols never exceed seven
	localparam int SW  = (MAX_STATES > 256) ? 8 :
		((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1);
	localparam int SYW = (ALPHABET > 128) ? 7 : $clog2(ALPHABET);
	localparam int AW  = SYW + SW;
	localparam int EW  = SW + 1;

	logic          clearing_q;
	logic [AW-1:0] clr_cnt_q;
	logic [SW-1:0] cur_q;
	logic          dead_q;
	logic          pend_q;
	logic          valid_s2;
	logic          dead_s2;
	logic          out_valid_q;
	logic          accepted_q;
	logic          went_dead_q;

	logic [EW-1:0] t_rdata;
	logic          f_rdata;
	logic [SW-1:0] cur_live;
	logic          dead_live;
	logic          s2_adv;
	logic          is_write;
	logic          is_mark;
	logic          is_feed;
	logic          is_kill;
	logic          is_end;
	logic          t_we;
	logic [AW-1:0] t_waddr;
	logic [EW-1:0] t_wdata;
	logic          t_re;
	logic [AW-1:0] t_raddr;
	logic          f_we;
	logic [SW-1:0] f_waddr;
	logic          f_wdata;
	logic          f_re;

	// Live run state: a pending table read supplies it straight from the store
	assign cur_live  = pend_q ? t_rdata[SW-1:0] : cur_q;
	assign dead_live = pend_q ? t_rdata[SW] : dead_q;

	// Pop unless the store is being cleared or an end-of-string would collide with a stalled result
	assign s2_adv = valid_s2 && (!out_valid_q || out_ready);
	assign q_pop  = q_valid && !clearing_q &&
		((q_op.op != OP_END) || !valid_s2 || s2_adv);

	assign is_write = q_pop && (q_op.op == OP_WRITE);
	assign is_mark  = q_pop && (q_op.op == OP_MARK);
	assign is_feed  = q_pop && (q_op.op == OP_FEED);
	assign is_kill  = q_pop && (q_op.op == OP_KILL);
	assign is_end   = q_pop && (q_op.op == OP_END);

	// Transition store ports: clearing pass or transition write, symbol step read
	assign t_we    = clearing_q || is_write;
	assign t_waddr = clearing_q ? clr_cnt_q : {q_op.sym[SYW-1:0], q_op.src[SW-1:0]};
	assign t_wdata = clearing_q ? {1'b1, {SW{1'b0}}} : {q_op.dst_dead, q_op.dst[SW-1:0]};
	assign t_re    = is_feed && !dead_live;
	assign t_raddr = {q_op.sym[SYW-1:0], cur_live};

	// Final-flag store ports
	assign f_we    = clearing_q || is_mark;
	assign f_waddr = clearing_q ? clr_cnt_q[SW-1:0] : q_op.src[SW-1:0];
	assign f_wdata = !clearing_q;
	assign f_re    = is_end;

	tdfa_ram #(
		.WIDTH (EW),
		.DEPTH (2 ** AW)
	) u_trans_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (t_re),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	tdfa_ram #(
		.WIDTH (1),
		.DEPTH (2 ** SW)
	) u_final_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.re    (f_re),
		.raddr (cur_live),
		.rdata (f_rdata)
	);

	// Clearing pass, run state, result stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_cnt_q   <= '0;
			cur_q       <= '0;
			dead_q      <= 1'b0;
			pend_q      <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == '1) begin
					clearing_q <= 1'b0;
				end
			end
			pend_q <= t_re;
			if (is_end) begin
				cur_q  <= '0;
				dead_q <= 1'b0;
			end else if (is_kill) begin
				cur_q  <= cur_live;
				dead_q <= 1'b1;
			end else begin
				cur_q  <= cur_live;
				dead_q <= dead_live;
			end
			if (is_end) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (is_end) begin
			dead_s2 <= dead_live;
		end
		if (s2_adv) begin
			accepted_q  <= f_rdata && !dead_s2;
			went_dead_q <= dead_s2;
		end
	end

	assign busy      = clearing_q;
	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;
	assign went_dead = went_dead_q;

endmodule

@@ hw/rtl/table_driven_dfa_matcher_unit.sv @@
// Top level of the DFA matcher: one request transaction per cycle sustained while
// no clearing pass runs and no result is stalled. A string-ending symbol passes the
// queue, the result stage and the output register before out_valid rises. Each
// symbol step is one registered transition-store read whose data feeds the next read
// address directly. Reset: a clearing pass writes every transition entry (ALPHABET
// and the state count, each rounded up to a power of two) and clears every final flag; in_ready stays low.
module table_driven_dfa_matcher_unit #(
	parameter int ALPHABET   = tdfa_pkg::ALPHABET_DEF,
	parameter int MAX_STATES = tdfa_pkg::MAX_STATES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [7:0] state_index,
	input  logic [6:0] symbol,
	input  logic [8:0] dest_state,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       accepted,
	output logic       went_dead
);

	import tdfa_pkg::*;

	logic     busy;
	logic     q_full;
	logic     push;
	tdfa_op_t push_op;
	logic     q_valid;
	tdfa_op_t q_op;
	logic     q_pop;

	tdfa_front #(
		.ALPHABET   (ALPHABET),
		.MAX_STATES (MAX_STATES)
	) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.state_index (state_index),
		.symbol      (symbol),
		.dest_state  (dest_state),
		.busy        (busy),
		.q_full      (q_full),
		.push        (push),
		.push_op     (push_op)
	);

	tdfa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_op    (q_op),
		.pop       (q_pop)
	);

	tdfa_exec #(
		.ALPHABET   (ALPHABET),
		.MAX_STATES (MAX_STATES)
	) u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.q_pop     (q_pop),
		.busy      (busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.accepted  (accepted),
		.went_dead (went_dead)
	);

endmodule

@@ hw/rtl/tdfa_checker.sv @@
// Port-level checker for the DFA matcher and its bind to the top level.
module tdfa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] req_type,
	input logic [6:0] symbol,
	input logic       out_valid,
	input logic       out_ready,
	input logic       accepted,
	input logic       went_dead
);

	import tdfa_pkg::*;

	logic       end_in;
	logic       res_out;
	logic [3:0] pending_q;

	assign end_in  = in_valid && in_ready && (req_type == REQ_FEED) && (symbol == 7'd0);
	assign res_out = out_valid && out_ready;

	// Track string ends accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (end_in && !res_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (!end_in && res_out) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// A stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(went_dead))
		else $error("result changed while stalled");

	// A dead run is never reported as accepted
	a_dead_not_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(accepted && went_dead))
		else $error("dead run reported as accepted");

	// Every result answers an earlier string end
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("result without a pending string end");

	// The first string end must pass the queue and the result stage before a result can appear
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		end_in && pending_q == 4'd0 |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind table_driven_dfa_matcher_unit tdfa_checker u_tdfa_checker (.*);
